// File: sv/spm_pkg.sv
package spm_pkg;

  localparam int unsigned MaxSteps = 200;

  typedef enum logic [2:0] {
    RegTarget   = 3'd0,
    RegTol      = 3'd1,
    RegStart    = 3'd2,
    RegDutyMin  = 3'd3,
    RegDutyMax  = 3'd4,
    RegGainP    = 3'd5,
    RegGainI    = 3'd6,
    RegGainD    = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    StMoving  = 2'd0,
    StReached = 2'd1,
    StLimit   = 2'd2,
    StIdle    = 2'd3
  } status_e;

  // Sequencer phases
  typedef enum logic [3:0] {
    PhIdle,
    PhDiv,
    PhAvg,
    PhMul,
    PhPidA,
    PhPidB,
    PhPidC,
    PhPidD,
    PhDuty,
    PhOut
  } phase_e;

  // Request to the serial multiplier, and its status
  typedef struct packed {
    logic               start;
    logic signed [31:0] a;
    logic        [15:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [47:0] prod;
  } mul_rsp_t;

  // Request to the serial divider, and its status
  typedef struct packed {
    logic        start;
    logic [22:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [22:0] quo;
  } div_rsp_t;

endpackage

// File: sv/speed_pid_position_mover.sv
// Closed-loop speed mover. A start item (kind 0) latches direction and stop level, and its
// result is valid in the cycle after acceptance; the same holds for a sample item (kind 1)
// while the mover is idle or once it has arrived. Any other sample runs a serial divide for
// the speed (23 quotient bits) and the average, then six serial multiplies on a shared
// shift-add unit (one bit per cycle) for the lead-lag filter and the PID sum, then clamping
// and output. One item is in work at a time; the result sits in an output register and
// in_stall_o stays high until it is taken.
module speed_pid_position_mover (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [15:0] position_i,
  input  logic [31:0] tick_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] duty_cycle_o,
  output logic        drive_on_o,
  output logic        direction_o,
  output logic [1:0]  status_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import spm_pkg::*;

  // Configuration
  logic [15:0] target_q, tol_q, start_q, dmin_q, dmax_q;
  logic [14:0] kp_q, ki_q, kd_q;

  // Mover state
  logic               active_q, active_d, up_q, up_d;
  logic [15:0]        stop_q, stop_d, ppos_q, ppos_d, avg_q, avg_d, duty_q, duty_d;
  logic [31:0]        ptick_q, ptick_d;
  logic [10:0]        goal_q, goal_d;
  logic [7:0]         steps_q, steps_d;
  logic signed [10:0] integ_q, integ_d;
  logic signed [23:0] filt_q, filt_d;

  // Work registers
  phase_e             ph_q, ph_d;
  logic [2:0]         mstep_q, mstep_d;
  logic [15:0]        pos_q, pos_d;
  logic [31:0]        tk_q, tk_d;
  logic signed [9:0]  err_q, err_d;
  logic signed [23:0] x_q, x_d;
  logic signed [9:0]  dd_q, dd_d;
  logic signed [47:0] acc_q, acc_d;
  logic signed [5:0]  pid_q, pid_d;
  logic               ov_q, ov_d, od_q, od_d, odir_q, odir_d;
  logic [1:0]         ost_q, ost_d;
  logic [15:0]        oduty_q, oduty_d;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  div_req_t dreq;
  div_rsp_t drsp;

  spm_mul u_mul (.clk_i, .rst_ni, .req_i(mreq), .rsp_o(mrsp));
  spm_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  logic               take, out_free, arrived;
  logic [15:0]        gap, dpos;
  logic [31:0]        dt;
  logic [14:0]        spd;
  logic signed [16:0] avg_sum;
  logic signed [16:0] err_raw;
  logic signed [9:0]  err_sat;
  logic signed [12:0] int_raw;
  logic signed [47:0] q15;
  logic signed [31:0] sum_s;
  logic [31:0]        sum_mag;
  logic [15:0]        tenths;
  logic [4:0]         quo10;
  logic signed [5:0]  sum_div;
  logic signed [17:0] duty_sum;
  logic [6:0]         dclamp;

  assign out_free   = !ov_q || !out_stall_i;
  assign in_stall_o = (ph_q != PhIdle) || ov_q;
  assign take       = in_valid_i && !in_stall_o;

  assign arrived = up_q ? (position_i >= stop_q) : (position_i <= stop_q);
  assign gap     = (target_q > pos_q) ? target_q - pos_q : pos_q - target_q;
  assign dpos    = (pos_q > ppos_q) ? pos_q - ppos_q : ppos_q - pos_q;
  assign dt      = (tk_q > ptick_q) ? tk_q - ptick_q : ptick_q - tk_q;
  assign dclamp  = (gap < 16'd40) ? 7'd40 : 7'(gap);
  assign spd     = (drsp.quo > 23'd32767) ? 15'h7fff : drsp.quo[14:0];

  // Floor shift of the accumulator by 15
  assign q15  = acc_q >>> 15;

  // Divide the PID sum by ten toward zero; anything past 209 saturates anyway
  assign sum_s   = 32'(q15);
  assign sum_mag = sum_s[31] ? 32'(-sum_s) : 32'(sum_s);
  assign tenths  = 16'(sum_mag[7:0]) * 16'd205;
  assign quo10   = (sum_mag > 32'd209) ? 5'd20 : tenths[15:11];
  assign sum_div = sum_s[31] ? -$signed({1'b0, quo10}) : $signed({1'b0, quo10});

  assign avg_sum = 17'(avg_q) + 17'(spd);
  assign err_raw = $signed({6'b0, goal_q}) - $signed({1'b0, avg_q});
  assign err_sat = (err_raw > 17'sd400) ? 10'sd400 :
                   (err_raw < -17'sd400) ? -10'sd400 : 10'(err_raw);
  assign int_raw = 13'(integ_q) + 13'(err_q);
  assign duty_sum = 18'($signed({2'b0, duty_q})) + 18'(pid_q);

  // Drive the serial units
  always_comb begin
    mreq = '0;
    dreq = '0;
    if (ph_q == PhDiv && !drsp.busy && !drsp.done) begin
      dreq.start = 1'b1;
      dreq.num   = 23'(dpos) * 23'd100;
      dreq.den   = (dt == 32'd0) ? 32'd1 : dt;
    end
    if (ph_q == PhMul && !mrsp.busy && !mrsp.done) begin
      mreq.start = 1'b1;
      case (mstep_q)
        3'd0:    begin mreq.a = 32'(err_sat); mreq.b = 16'd32767; end
        3'd1:    begin mreq.a = 32'(filt_q);  mreq.b = 16'd29261; end
        3'd2:    begin mreq.a = 32'(x_q - filt_q); mreq.b = 16'd32767; end
        3'd3:    begin mreq.a = 32'(err_q);   mreq.b = {1'b0, kp_q}; end
        3'd4:    begin mreq.a = 32'(integ_q); mreq.b = {1'b0, ki_q}; end
        default: begin mreq.a = 32'(dd_q);    mreq.b = {1'b0, kd_q}; end
      endcase
    end
  end

  // Next state of the sequencer
  always_comb begin
    ph_d = ph_q;
    case (ph_q)
      PhIdle: if (take && kind_i && active_q && !arrived) ph_d = PhDiv;
      PhDiv:  if (drsp.done) ph_d = PhAvg;
      PhAvg:  ph_d = PhMul;
      PhMul:  if (mrsp.done) begin
        case (mstep_q)
          3'd1:    ph_d = PhPidA;
          3'd2:    ph_d = PhPidB;
          3'd5:    ph_d = PhPidC;
          default: ph_d = PhMul;
        endcase
      end
      PhPidA: ph_d = PhMul;
      PhPidB: ph_d = PhMul;
      PhPidC: ph_d = PhPidD;
      PhPidD: ph_d = PhDuty;
      PhDuty: ph_d = PhOut;
      PhOut:  if (out_free) ph_d = PhIdle;
      default: ph_d = PhIdle;
    endcase
  end

  // Datapath updates
  always_comb begin
    active_d = active_q; up_d = up_q; stop_d = stop_q; ppos_d = ppos_q;
    avg_d = avg_q; duty_d = duty_q; ptick_d = ptick_q; goal_d = goal_q;
    steps_d = steps_q; integ_d = integ_q; filt_d = filt_q;
    mstep_d = mstep_q; pos_d = pos_q; tk_d = tk_q; err_d = err_q;
    x_d = x_q; dd_d = dd_q; acc_d = acc_q; pid_d = pid_q;
    ov_d = ov_q; od_d = od_q; odir_d = odir_q; ost_d = ost_q; oduty_d = oduty_q;

    if (ov_q && !out_stall_i) ov_d = 1'b0;

    case (ph_q)
      PhIdle: if (take) begin
        pos_d = position_i;
        tk_d  = tick_i;
        if (!kind_i) begin
          up_d     = target_q > position_i;
          stop_d   = (target_q > position_i) ? target_q - tol_q : target_q + tol_q;
          integ_d  = '0;
          filt_d   = '0;
          avg_d    = '0;
          goal_d   = 11'd1000;
          duty_d   = start_q;
          steps_d  = 8'(MaxSteps);
          ppos_d   = position_i;
          ptick_d  = tick_i;
          active_d = 1'b1;
          ov_d = 1'b1; od_d = 1'b1; odir_d = target_q > position_i;
          ost_d = StMoving; oduty_d = start_q;
        end else if (!active_q) begin
          ov_d = 1'b1; od_d = 1'b0; odir_d = up_q; ost_d = StIdle; oduty_d = duty_q;
        end else if (arrived) begin
          active_d = 1'b0;
          ov_d = 1'b1; od_d = 1'b0; odir_d = up_q; ost_d = StReached; oduty_d = duty_q;
        end
      end
      PhAvg: begin
        if (gap < 16'd100) goal_d = 11'(dclamp) * 11'd10;
        avg_d = 16'(avg_sum[16:1]);
        mstep_d = 3'd0;
        acc_d   = '0;
      end
      PhMul: begin
        // error is ready once goal and average are in
        if (mstep_q == 3'd0 && !mrsp.busy && !mrsp.done) err_d = err_sat;
        if (mstep_q == 3'd3 && !mrsp.busy && !mrsp.done) begin
          if (int_raw > 13'sd1000)       integ_d = 11'sd1000;
          else if (int_raw < -13'sd1000) integ_d = -11'sd1000;
          else                           integ_d = 11'(int_raw);
        end
        if (mrsp.done) begin
          acc_d   = acc_q + mrsp.prod;
          mstep_d = mstep_q + 3'd1;
        end
      end
      PhPidA: begin
        x_d   = 24'(q15);
        acc_d = '0;
      end
      PhPidB: begin
        if (q15 > 48'sd400)       dd_d = 10'sd400;
        else if (q15 < -48'sd400) dd_d = -10'sd400;
        else                      dd_d = 10'(q15);
        filt_d = x_q;
        acc_d  = '0;
      end
      PhPidC: begin
        pid_d = sum_div;
      end
      PhPidD: ;
      PhDuty: begin
        if (duty_sum < $signed({2'b0, dmin_q}))      duty_d = dmin_q;
        else if (duty_sum > $signed({2'b0, dmax_q})) duty_d = dmax_q;
        else                                          duty_d = duty_sum[15:0];
        ppos_d  = pos_q;
        ptick_d = tk_q;
        if (steps_q != 8'd0) steps_d = steps_q - 8'd1;
      end
      PhOut: if (out_free) begin
        ov_d = 1'b1; oduty_d = duty_q; odir_d = up_q;
        if (steps_q == 8'd0) begin
          active_d = 1'b0; od_d = 1'b0; ost_d = StLimit;
        end else begin
          od_d = 1'b1; ost_d = StMoving;
        end
      end
      default: ;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= 16'd0; tol_q <= 16'd1; start_q <= 16'd144;
      dmin_q <= 16'd0; dmax_q <= 16'd1000;
      kp_q <= 15'd15000; ki_q <= 15'd2768; kd_q <= 15'd15000;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        RegTarget:  target_q <= cfg_data_i;
        RegTol:     tol_q    <= cfg_data_i;
        RegStart:   start_q  <= cfg_data_i;
        RegDutyMin: dmin_q   <= cfg_data_i;
        RegDutyMax: dmax_q   <= cfg_data_i;
        RegGainP:   kp_q     <= cfg_data_i[14:0];
        RegGainI:   ki_q     <= cfg_data_i[14:0];
        RegGainD:   kd_q     <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // Control and mover state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PhIdle; active_q <= 1'b0; up_q <= 1'b0; stop_q <= '0; ppos_q <= '0;
      avg_q <= '0; duty_q <= '0; ptick_q <= '0; goal_q <= 11'd1000; steps_q <= '0;
      integ_q <= '0; filt_q <= '0; mstep_q <= '0; ov_q <= 1'b0;
    end else begin
      ph_q <= ph_d; active_q <= active_d; up_q <= up_d; stop_q <= stop_d;
      ppos_q <= ppos_d; avg_q <= avg_d; duty_q <= duty_d; ptick_q <= ptick_d;
      goal_q <= goal_d; steps_q <= steps_d; integ_q <= integ_d; filt_q <= filt_d;
      mstep_q <= mstep_d; ov_q <= ov_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; tk_q <= tk_d; err_q <= err_d; x_q <= x_d; dd_q <= dd_d;
    acc_q <= acc_d; pid_q <= pid_d; od_q <= od_d; odir_q <= odir_d;
    ost_q <= ost_d; oduty_q <= oduty_d;
  end

  assign out_valid_o  = ov_q;
  assign duty_cycle_o = oduty_q;
  assign drive_on_o   = od_q;
  assign direction_o  = odir_q;
  assign status_o     = ost_q;
endmodule

// File: sv/spm_mul.sv
// Shift-add multiplier: signed a times unsigned b, one bit of b per cycle.
module spm_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spm_pkg::mul_req_t req_i,
  output spm_pkg::mul_rsp_t rsp_o
);
  import spm_pkg::*;

  logic               busy_q, busy_d, done_q, done_d;
  logic [4:0]         cnt_q, cnt_d;
  logic signed [47:0] acc_q, acc_d, mcand_q, mcand_d;
  logic [15:0]        mplier_q, mplier_d;

  // Add one partial product per cycle
  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    if (req_i.start) begin
      busy_d   = 1'b1;
      cnt_d    = 5'd0;
      acc_d    = '0;
      mcand_d  = 48'(req_i.a);
      mplier_d = req_i.b;
    end else if (busy_q) begin
      if (mplier_q[0]) acc_d = acc_q + mcand_q;
      mcand_d  = mcand_q <<< 1;
      mplier_d = mplier_q >> 1;
      cnt_d    = cnt_q + 5'd1;
      if (cnt_q == 5'd15) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;
endmodule

// File: sv/spm_div.sv
// Restoring divider: one quotient bit per cycle.
module spm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spm_pkg::div_req_t req_i,
  output spm_pkg::div_rsp_t rsp_o
);
  import spm_pkg::*;

  logic        busy_q, busy_d, done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [22:0] quo_q, quo_d;
  logic [31:0] rem_q, rem_d, den_q, den_d;
  logic [32:0] trial;

  // Shift in one numerator bit, subtract when it fits
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    trial  = {rem_q, quo_q[22]} - {1'b0, den_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 5'd0;
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[21:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quo_q[22]};
        quo_d = {quo_q[21:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd22) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
endmodule

// File: sv/spm_checker.sv
module spm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] duty_cycle_o,
  input logic        drive_on_o,
  input logic [1:0]  status_o
);
  import spm_pkg::*;

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(duty_cycle_o))
    else $error("stalled result changed");

  // Drive runs exactly while moving
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (drive_on_o == (status_o == StMoving)))
    else $error("drive_on does not match status");

  // No new item while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("item taken while result pending");

  // An accepted item leads to a result before another is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("back-to-back accept");
endmodule

bind speed_pid_position_mover spm_checker u_spm_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .duty_cycle_o, .drive_on_o, .status_o
);

// File: verif/speed_pid_position_mover_tb.sv
`timescale 1ns / 100ps

module speed_pid_position_mover_tb;
  import spm_pkg::*;

  localparam int unsigned DirectedLen = 20;

  // Directed stimulus row; check_fixed marks rows with a typed-in result
  typedef struct {
    logic        kind;
    logic [15:0] position;
    logic [31:0] tick;
    logic        check_fixed;
    logic [15:0] duty;
    logic        drive;
    logic        dir;
    status_e     status;
  } stim_row_t;

  typedef struct packed {
    logic [15:0] duty;
    logic        drive;
    logic        dir;
    logic [1:0]  status;
  } mover_out_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        kind_i;
  logic [15:0] position_i;
  logic [31:0] tick_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [15:0] duty_cycle_o;
  logic        drive_on_o;
  logic        direction_o;
  logic [1:0]  status_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  speed_pid_position_mover uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .position_i   (position_i),
    .tick_i       (tick_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .duty_cycle_o (duty_cycle_o),
    .drive_on_o   (drive_on_o),
    .direction_o  (direction_o),
    .status_o     (status_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Predictor copy of the registers
  logic [15:0] mv_target, mv_tol, mv_start, mv_dmin, mv_dmax;
  logic [14:0] mv_kp, mv_ki, mv_kd;

  // Predictor copy of the mover state
  logic        mv_active, mv_up;
  logic [15:0] mv_stop, mv_prev_pos, mv_avg, mv_duty;
  logic [31:0] mv_prev_tick;
  int          mv_goal, mv_integral, mv_filter;
  int unsigned mv_steps;

  mover_out_t  duty_queue[$];
  int unsigned errors;
  int unsigned accepted;
  int unsigned send_idle_pct, recv_idle_pct;
  bit          hold_recv;
  bit          stim_done;
  stim_row_t   rows[DirectedLen];

  function automatic longint clamp64(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  // Floor shift right by 15
  function automatic longint floor_q15(longint x);
    return x >>> 15;
  endfunction

  function automatic int pid_update(int err_raw);
    longint err, x, d, sum;
    err = clamp64(err_raw, -400, 400);
    mv_integral = int'(clamp64(longint'(mv_integral) + err, -1000, 1000));
    x = floor_q15(32767 * err + 29261 * longint'(mv_filter));
    d = floor_q15(32767 * x - 32767 * longint'(mv_filter));
    mv_filter = int'(x);
    d = clamp64(d, -400, 400);
    sum = floor_q15(longint'(mv_kp) * err + longint'(mv_ki) * mv_integral
                    + longint'(mv_kd) * d);
    sum = sum / 10;
    return int'(clamp64(sum, -20, 20));
  endfunction

  function automatic void mover_reset();
    mv_target = 0; mv_tol = 1; mv_start = 144; mv_dmin = 0; mv_dmax = 1000;
    mv_kp = 15000; mv_ki = 2768; mv_kd = 15000;
    mv_active = 0; mv_up = 0; mv_stop = 0; mv_prev_pos = 0; mv_prev_tick = 0;
    mv_avg = 0; mv_goal = 1000; mv_duty = 0; mv_steps = 0;
    mv_integral = 0; mv_filter = 0;
  endfunction

  // Work out the result of one accepted item
  function automatic mover_out_t predict_duty(logic kind, logic [15:0] pos,
                                             logic [31:0] tk);
    mover_out_t  r;
    longint      remain, dpos, dt, spd, sum;
    logic [1:0]  st;
    logic        drv;
    st = StMoving;
    drv = 1;
    if (!kind) begin
      mv_up = mv_target > pos;
      mv_stop = mv_up ? mv_target - mv_tol : mv_target + mv_tol;
      mv_integral = 0; mv_filter = 0; mv_avg = 0; mv_goal = 1000;
      mv_duty = mv_start; mv_steps = MaxSteps;
      mv_prev_pos = pos; mv_prev_tick = tk; mv_active = 1;
    end else if (!mv_active) begin
      drv = 0; st = StIdle;
    end else if ((mv_up && pos >= mv_stop) || (!mv_up && pos <= mv_stop)) begin
      mv_active = 0; drv = 0; st = StReached;
    end else begin
      remain = mv_target > pos ? mv_target - pos : pos - mv_target;
      dpos = pos > mv_prev_pos ? pos - mv_prev_pos : mv_prev_pos - pos;
      dt = tk > mv_prev_tick ? longint'(tk - mv_prev_tick) : longint'(mv_prev_tick - tk);
      if (remain < 100) mv_goal = 10 * int'(clamp64(remain, 40, 100));
      if (dt == 0) dt = 1;
      spd = (dpos * 100) / dt;
      if (spd > 32767) spd = 32767;
      mv_avg = 16'((longint'(mv_avg) + spd) / 2);
      sum = longint'(mv_duty) + pid_update(mv_goal - int'(mv_avg));
      if (sum < longint'(mv_dmin)) sum = mv_dmin;
      else if (sum > longint'(mv_dmax)) sum = mv_dmax;
      mv_duty = sum[15:0];
      mv_prev_pos = pos; mv_prev_tick = tk;
      if (mv_steps > 0) mv_steps--;
      if (mv_steps == 0) begin
        mv_active = 0; drv = 0; st = StLimit;
      end
    end
    r.duty = mv_duty; r.drive = drv; r.dir = mv_up; r.status = st;
    return r;
  endfunction

  // Clock
  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit on run time
  initial begin
    #60_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: random stall, with a long hold-off on request
  always @(posedge clk_i) begin
    out_stall_i <= hold_recv || ($urandom_range(99) < recv_idle_pct);
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    mover_out_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {duty_cycle_o, drive_on_o, direction_o, status_o};
      if (duty_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
      end else begin
        want = duty_queue.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  // Write one register, then drop the write enable before updating the predictor copy
  task automatic write_reg(reg_idx_e idx, logic [15:0] val);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    @(posedge clk_i);
    case (idx)
      RegTarget:  mv_target = val;
      RegTol:     mv_tol = val;
      RegStart:   mv_start = val;
      RegDutyMin: mv_dmin = val;
      RegDutyMax: mv_dmax = val;
      RegGainP:   mv_kp = val[14:0];
      RegGainI:   mv_ki = val[14:0];
      default:    mv_kd = val[14:0];
    endcase
  endtask

  // Offer one item and hold it until taken; optional fixed expectation
  task automatic send_item(logic kind, logic [15:0] pos, logic [31:0] tk,
                           logic fixed, mover_out_t want);
    mover_out_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1; kind_i <= kind; position_i <= pos; tick_i <= tk;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    p = predict_duty(kind, pos, tk);
    duty_queue.push_back(fixed ? want : p);
    accepted++;
  endtask

  // Drop valid, wait until every expected result has come or the wait limit is reached, then let the block settle
  task automatic drain();
    int unsigned n;
    n = 0;
    in_valid_i <= 0;
    while (duty_queue.size() != 0 && n < 200000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (300) @(posedge clk_i);
  endtask

  // One well-formed move with random content, ending in noise sometimes
  task automatic random_move(int unsigned len);
    logic [15:0] pos;
    logic [31:0] tk;
    int          stepv;
    mover_out_t  none;
    none = '0;
    pos = 16'($urandom);
    tk = $urandom;
    send_item(0, pos, tk, 0, none);
    for (int unsigned i = 0; i < len; i++) begin
      stepv = $urandom_range(400);
      if ($urandom_range(9) == 0) pos = 16'($urandom);
      else pos = 16'(mv_up ? pos + stepv : pos - stepv);
      if ($urandom_range(19) == 0) tk = tk;
      else if ($urandom_range(19) == 0) tk = $urandom;
      else tk = tk + $urandom_range(1, 60);
      send_item(1, pos, tk, 0, none);
    end
  endtask

  initial begin
    mover_out_t  want;
    logic [15:0] cfg_vals[8];
    rst_ni = 0; in_valid_i = 0; kind_i = 0; position_i = 0; tick_i = 0;
    cfg_we_i = 0; cfg_idx_i = RegTarget; cfg_data_i = 0;
    hold_recv = 0; errors = 0; accepted = 0; stim_done = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    mover_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed table: idle sample, start, arrival, extremes, steady moves
    rows[0]  = '{1, 16'h0000, 32'h0, 1, 16'd0, 0, 0, StIdle};
    rows[1]  = '{1, 16'hFFFF, 32'hFFFF_FFFF, 1, 16'd0, 0, 0, StIdle};
    rows[2]  = '{0, 16'h0000, 32'd0, 1, 16'd144, 1, 0, StMoving};
    rows[3]  = '{1, 16'h0000, 32'd5, 1, 16'd144, 0, 0, StReached};
    rows[4]  = '{1, 16'h0000, 32'd6, 1, 16'd144, 0, 0, StIdle};
    rows[5]  = '{0, 16'hFFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, StMoving};
    rows[6]  = '{1, 16'hFFF0, 32'hFFFF_FFFF, 0, 0, 0, 0, StMoving};
    rows[7]  = '{1, 16'hFF00, 32'h0, 0, 0, 0, 0, StMoving};
    rows[8]  = '{1, 16'h8000, 32'h7FFF_FFFF, 0, 0, 0, 0, StMoving};
    rows[9]  = '{1, 16'h7000, 32'h7FFF_FFF0, 0, 0, 0, 0, StMoving};
    rows[10] = '{1, 16'h0050, 32'h7FFF_FFF8, 0, 0, 0, 0, StMoving};
    rows[11] = '{1, 16'h0001, 32'h7FFF_FFF9, 0, 0, 0, 0, StMoving};
    rows[12] = '{1, 16'h0000, 32'h8000_0000, 0, 0, 0, 0, StMoving};
    rows[13] = '{0, 16'h1234, 32'h0000_1000, 0, 0, 0, 0, StMoving};
    rows[14] = '{1, 16'h1200, 32'h0000_1001, 0, 0, 0, 0, StMoving};
    rows[15] = '{1, 16'h11F0, 32'h0000_1003, 0, 0, 0, 0, StMoving};
    rows[16] = '{1, 16'h1100, 32'h0000_1010, 0, 0, 0, 0, StMoving};
    rows[17] = '{1, 16'h0040, 32'h0000_1020, 0, 0, 0, 0, StMoving};
    rows[18] = '{1, 16'h0010, 32'h0000_1030, 0, 0, 0, 0, StMoving};
    rows[19] = '{1, 16'h0001, 32'h0000_1030, 0, 0, 0, 0, StMoving};
    for (int i = 0; i < DirectedLen; i++) begin
      want = {rows[i].duty, rows[i].drive, rows[i].dir, rows[i].status};
      send_item(rows[i].kind, rows[i].position, rows[i].tick,
                rows[i].check_fixed, want);
    end
    drain();

    // Moves toward a mid-range target; tolerance 0 and high gains
    write_reg(RegTarget, 16'h8000);
    write_reg(RegTol, 16'd0);
    write_reg(RegGainP, 16'h7FFF);
    write_reg(RegGainI, 16'h7FFF);
    write_reg(RegGainD, 16'h7FFF);
    write_reg(RegDutyMax, 16'hFFFF);
    write_reg(RegStart, 16'hFFFF);
    send_idle_pct = 23; recv_idle_pct = 75;
    for (int i = 0; i < 8; i++) random_move($urandom_range(3, 30));

    // Long receiver hold-off while items keep coming
    fork
      begin
        hold_recv = 1;
        repeat (2000) @(posedge clk_i);
        hold_recv = 0;
      end
      random_move(6);
    join
    drain();

    // Crossed duty limits, zero gains, wrapped stop level
    write_reg(RegDutyMin, 16'd900);
    write_reg(RegDutyMax, 16'd100);
    write_reg(RegGainP, 16'd0);
    write_reg(RegGainI, 16'd0);
    write_reg(RegGainD, 16'd0);
    write_reg(RegTol, 16'hFFFF);
    write_reg(RegStart, 16'd0);
    send_idle_pct = 75; recv_idle_pct = 23;
    for (int i = 0; i < 8; i++) random_move($urandom_range(3, 30));
    drain();

    // Random registers, one step-limit run, then no idling
    for (int i = 0; i < 8; i++) cfg_vals[i] = 16'($urandom);
    write_reg(RegTarget, cfg_vals[0]);
    write_reg(RegTol, cfg_vals[1] & 16'h00FF);
    write_reg(RegStart, cfg_vals[2]);
    write_reg(RegDutyMin, cfg_vals[3] & 16'h03FF);
    write_reg(RegDutyMax, cfg_vals[4] | 16'h0400);
    write_reg(RegGainP, cfg_vals[5]);
    write_reg(RegGainI, cfg_vals[6]);
    write_reg(RegGainD, cfg_vals[7]);
    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(RegTarget, 16'h0000);
    write_reg(RegTol, 16'h0000);
    random_move(205);
    drain();
    write_reg(RegTarget, cfg_vals[0]);
    while (accepted < 870) random_move($urandom_range(3, 30));
    drain();

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
